// ----- hdl/sample_playback_mixer_top_assert.svh -----
// Assertion macros for the sample playback mixer.
// The module that uses them provides aclk and aresetn.
`ifndef SAMPLE_PLAYBACK_MIXER_TOP_ASSERT_SVH
`define SAMPLE_PLAYBACK_MIXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define SPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SPM_ASSERT_IMP(lbl, ante, cons, msg)
`define SPM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hdl/spm_pkg.sv -----
`default_nettype none
package spm_pkg;

    // Defaults for the top level parameters, and the operation queue depth
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int SAMPLE_DEPTH_DEF = 65536;
    localparam int QUEUE_DEPTH      = 4;

    // Mix limits and gain format
    localparam logic signed [15:0] MIX_MAX = 16'sd32767;
    localparam logic signed [15:0] MIX_MIN = -16'sd32767;
    localparam logic [16:0]        MAX_LEN = 17'h10000;
    localparam int                 GAIN_FRAC = 10;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    // Input item as it arrives on the port
    typedef struct packed {
        cmd_t               cmd;
        logic [2:0]         channel;
        logic [15:0]        sample_address;
        logic signed [15:0] sample_value;
        logic [16:0]        play_length;
        logic               loop_flag;
        logic [10:0]        volume;
    } spm_in_t;

    // Result item
    typedef struct packed {
        logic signed [15:0] mixed_sample;
        logic [7:0]         active_mask;
    } spm_out_t;

    // Classified operation passed from front to back (address travels apart)
    typedef struct packed {
        cmd_t               kind;
        logic [2:0]         channel;
        logic signed [15:0] value;
        logic [16:0]        length;
        logic               loop_en;
        logic [10:0]        gain;
    } spm_op_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_REDUCE,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ISSUE,
        B_DRAIN,
        B_DONE
    } back_state_t;

endpackage
`default_nettype wire

// ----- hdl/spm_front.sv -----
`default_nettype none
module spm_front #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_DEPTH = 65536,
    localparam int AW = $clog2(SAMPLE_DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire spm_pkg::spm_in_t  s_data,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output spm_pkg::spm_op_t       push_op,
    output logic [AW-1:0]          push_addr
);
    import spm_pkg::*;

    // Addresses need folding only when the memory is smaller than the address space
    localparam bit REDUCE    = SAMPLE_DEPTH < 65536;
    localparam int RED_STEPS = REDUCE ? 16 - $clog2(SAMPLE_DEPTH) : 0;

    front_state_t state_reg, state_next;
    spm_op_t      op_reg;
    logic [15:0]  rem_reg;
    logic [3:0]   step_reg;

    logic        accept;
    logic        drop;
    logic        needs_fold;
    logic [16:0] sub_val;
    logic        sub_fits;

    assign accept     = s_valid && s_ready;
    // A start naming a channel that does not exist is taken and discarded
    assign drop       = (s_data.cmd == CMD_START) && (int'(s_data.channel) >= NUM_CHANNELS);
    assign needs_fold = REDUCE && ((s_data.cmd == CMD_WRITE) || (s_data.cmd == CMD_START));
    assign sub_val    = 17'(SAMPLE_DEPTH) << step_reg;
    assign sub_fits   = {1'b0, rem_reg} >= sub_val;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && !drop) begin
                    state_next = needs_fold ? F_REDUCE : F_PUSH;
                end
            end
            F_REDUCE: begin
                if (step_reg == 4'd0) begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    // Item capture and address folding, one shifted subtract a cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg.kind    <= s_data.cmd;
            op_reg.channel <= s_data.channel;
            op_reg.value   <= s_data.sample_value;
            op_reg.length  <= (s_data.play_length > MAX_LEN) ? MAX_LEN : s_data.play_length;
            op_reg.loop_en <= s_data.loop_flag;
            op_reg.gain    <= s_data.volume;
            rem_reg        <= s_data.sample_address;
            step_reg       <= 4'(RED_STEPS);
        end else if (state_reg == F_REDUCE) begin
            if (sub_fits) begin
                rem_reg <= 16'({1'b0, rem_reg} - sub_val);
            end
            step_reg <= step_reg - 4'd1;
        end
    end

    assign push_op   = op_reg;
    assign push_addr = AW'(rem_reg);

endmodule
`default_nettype wire

// ----- hdl/spm_queue.sv -----
`default_nettype none
module spm_queue #(
    parameter int DEPTH = 4,
    parameter int AW    = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire spm_pkg::spm_op_t  push_op,
    input  wire logic [AW-1:0]     push_addr,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output spm_pkg::spm_op_t       q_op,
    output logic [AW-1:0]          q_addr
);
    import spm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    spm_op_t       op_reg   [DEPTH];
    logic [AW-1:0] addr_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   count_reg;

    logic do_push, do_pop;

    assign push_ready = count_reg != (PW+1)'(DEPTH);
    assign q_valid    = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = q_pop && q_valid;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            op_reg[wr_ptr_reg]   <= push_op;
            addr_reg[wr_ptr_reg] <= push_addr;
        end
    end

    assign q_op   = op_reg[rd_ptr_reg];
    assign q_addr = addr_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// ----- hdl/spm_back.sv -----
`default_nettype none
`include "sample_playback_mixer_top_assert.svh"
module spm_back #(
    parameter int NUM_CHANNELS = 8,
    parameter int SAMPLE_DEPTH = 65536,
    localparam int AW = $clog2(SAMPLE_DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  wire spm_pkg::spm_op_t  q_op,
    input  wire logic [AW-1:0]     q_addr,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output spm_pkg::spm_out_t      m_data
);
    import spm_pkg::*;

    localparam int CIW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MW  = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;

    // Sample memory, one port
    logic signed [15:0] mem [SAMPLE_DEPTH];

    // Per-channel state
    logic [NUM_CHANNELS-1:0] active_reg;
    logic [AW-1:0]           base_reg [NUM_CHANNELS];
    logic [AW-1:0]           ptr_reg  [NUM_CHANNELS];
    logic [15:0]             off_reg  [NUM_CHANNELS];
    logic [16:0]             len_reg  [NUM_CHANNELS];
    logic                    loop_reg [NUM_CHANNELS];
    logic [10:0]             gain_reg [NUM_CHANNELS];

    back_state_t state_reg, state_next;
    logic [CIW-1:0] k_reg;
    logic           drain_reg;

    // Mix pipeline: read, multiply, accumulate
    logic signed [15:0] mem_rd_reg;
    logic [10:0]        gain1_reg;
    logic               v1_reg, v2_reg;
    logic signed [27:0] prod_reg;
    logic signed [15:0] sum_reg;

    logic               m_valid_reg;
    spm_out_t           m_data_reg;

    logic               out_load;
    logic               k_last;
    logic [CIW-1:0]     start_idx;
    logic [16:0]        off_inc;
    logic               at_end;
    logic [AW-1:0]      ptr_inc;
    logic signed [17:0] term;
    logic signed [18:0] acc;
    logic signed [15:0] acc_sat;

    assign k_last    = k_reg == CIW'(NUM_CHANNELS-1);
    assign start_idx = CIW'(q_op.channel);
    assign off_inc   = {1'b0, off_reg[k_reg]} + 17'd1;
    assign at_end    = off_inc >= len_reg[k_reg];
    assign ptr_inc   = (ptr_reg[k_reg] == AW'(SAMPLE_DEPTH-1)) ? '0 : ptr_reg[k_reg] + AW'(1);

    // floor(product / 1024) then saturating add
    assign term = prod_reg[27:GAIN_FRAC];
    assign acc  = 19'(sum_reg) + 19'(term);
    always_comb begin
        if (acc > 19'(MIX_MAX)) begin
            acc_sat = MIX_MAX;
        end else if (acc < 19'(MIX_MIN)) begin
            acc_sat = MIX_MIN;
        end else begin
            acc_sat = acc[15:0];
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state, queue pop and result load
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_op.kind == CMD_TICK) begin
                        state_next = B_ISSUE;
                    end
                end
            end
            B_ISSUE: begin
                if (k_last) begin
                    state_next = B_DRAIN;
                end
            end
            B_DRAIN: begin
                if (drain_reg) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Memory write on a write item, read for the channel being visited
    always_ff @(posedge aclk) begin
        if (q_pop && q_op.kind == CMD_WRITE) begin
            mem[q_addr] <= q_op.value;
        end
        if (state_reg == B_ISSUE) begin
            mem_rd_reg <= mem[ptr_reg[k_reg]];
        end
    end

    // Channel parameters and play position
    always_ff @(posedge aclk) begin
        if (q_pop && q_op.kind == CMD_START) begin
            base_reg[start_idx] <= q_addr;
            ptr_reg[start_idx]  <= q_addr;
            off_reg[start_idx]  <= '0;
            len_reg[start_idx]  <= q_op.length;
            loop_reg[start_idx] <= q_op.loop_en;
            gain_reg[start_idx] <= q_op.gain;
        end else if (state_reg == B_ISSUE && active_reg[k_reg]) begin
            if (at_end && loop_reg[k_reg]) begin
                off_reg[k_reg] <= '0;
                ptr_reg[k_reg] <= base_reg[k_reg];
            end else begin
                off_reg[k_reg] <= off_inc[15:0];
                ptr_reg[k_reg] <= ptr_inc;
            end
        end
    end

    // Active flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
        end else if (q_pop && q_op.kind == CMD_START) begin
            active_reg[start_idx] <= q_op.length != '0;
        end else if (q_pop && q_op.kind == CMD_STOP) begin
            active_reg <= '0;
        end else if (state_reg == B_ISSUE && active_reg[k_reg] && at_end &&
                     !loop_reg[k_reg]) begin
            active_reg[k_reg] <= 1'b0;
        end
    end

    // Channel counter and drain timer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= '0;
            drain_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                k_reg <= '0;
            end else if (state_reg == B_ISSUE) begin
                k_reg <= k_reg + CIW'(1);
            end
            drain_reg <= (state_reg == B_DRAIN) && !drain_reg;
        end
    end

    // Pipeline valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == B_ISSUE) && active_reg[k_reg];
            v2_reg <= v1_reg;
        end
    end

    // Gain, product and running sum
    always_ff @(posedge aclk) begin
        gain1_reg <= gain_reg[k_reg];
        prod_reg  <= 28'(mem_rd_reg) * 28'($signed({1'b0, gain1_reg}));
        if (q_pop && q_op.kind == CMD_TICK) begin
            sum_reg <= '0;
        end else if (v2_reg) begin
            sum_reg <= acc_sat;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.mixed_sample <= sum_reg;
            m_data_reg.active_mask  <= 8'(active_reg[MW-1:0]);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `SPM_ASSERT_IMP(a_sum_clamped, state_reg == B_DONE, sum_reg != -16'sd32768, "mix out of range")
    `SPM_ASSERT_NXT(a_done_loads, state_reg == B_DONE && (!m_valid_reg || m_ready), m_valid_reg && state_reg == B_IDLE, "result not loaded")
    `SPM_ASSERT_NXT(a_drain_two, state_reg == B_ISSUE && k_last, state_reg == B_DRAIN ##1 state_reg == B_DRAIN ##1 state_reg == B_DONE, "drain length wrong")
    `SPM_ASSERT_IMP(a_idle_empty, state_reg == B_IDLE, !v1_reg && !v2_reg, "pipeline busy in idle")
    `SPM_ASSERT_IMP(a_high_chan_idle, 1'b1, (active_reg >> 8) == '0, "unreachable channel active")

endmodule
`default_nettype wire

// ----- hdl/sample_playback_mixer_top.sv -----
// Tick item: the front end passes it to the queue; the back end then visits every channel
// with one memory read port and one multiplier, one channel a cycle, waits on the drain timer
// and loads the result; the back end takes its next item only after that result is loaded.
// Write, start and stop items pass the front end and are executed as the back end pops them; write
// and start items have their address folded in the front end when SAMPLE_DEPTH is below 65536.
// Reset (aresetn low, synchronous) idles all channels, empties queue and output, keeps memory.
`default_nettype none
module sample_playback_mixer_top #(
    parameter int NUM_CHANNELS = spm_pkg::NUM_CHANNELS_DEF,
    parameter int SAMPLE_DEPTH = spm_pkg::SAMPLE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire spm_pkg::spm_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output spm_pkg::spm_out_t      m_data
);
    import spm_pkg::*;

    localparam int AW = $clog2(SAMPLE_DEPTH);

    logic          push_valid, push_ready;
    spm_op_t       push_op;
    logic [AW-1:0] push_addr;
    logic          q_valid, q_pop;
    spm_op_t       q_op;
    logic [AW-1:0] q_addr;

    // Accept and classify
    spm_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .push_addr  (push_addr)
    );

    // Operation queue
    spm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_op    (push_op),
        .push_addr  (push_addr),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_op       (q_op),
        .q_addr     (q_addr)
    );

    // Execute and mix
    spm_back #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SAMPLE_DEPTH (SAMPLE_DEPTH)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_op    (q_op),
        .q_addr  (q_addr),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire
